// ===== hdl/pdeq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdeq_pkg
// Shared constants and types for the packet delay emulator queue.
// ----------------------------------------------------------------------------
package pdeq_pkg;

    localparam int CAPACITY_DEF    = 32;
    localparam int FLUSH_COUNT_DEF = 16;

    localparam int CMD_W      = 2;
    localparam int TAG_W      = 16;
    localparam int TIME_W     = 32;
    localparam int DELAY_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_ARRIVE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAIN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY_EN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEL_IN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEL_OUT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IN_DELAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_DELAY  = 3'd4;

    localparam logic               DELAY_EN_RST  = 1'b0;
    localparam logic               SEL_IN_RST    = 1'b1;
    localparam logic               SEL_OUT_RST   = 1'b1;
    localparam logic [DELAY_W-1:0] IN_DELAY_RST  = 16'd50;
    localparam logic [DELAY_W-1:0] OUT_DELAY_RST = 16'd50;

    typedef struct packed {
        logic              outbound;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    localparam int ENTRY_W = 1 + TAG_W + TIME_W;

endpackage

// ===== hdl/pdeq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdeq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pdeq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/packet_delay_emulator_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_delay_emulator_queue_top
// Holds packet tags in an oldest-first store and releases them after a
// per-direction delay, on tick, on overflow flush or on drain.
// Arrive and status-only requests give one result each; no new request is
// taken until it is issued. Tick: a first pass counts the surviving entries,
// a second releases and compacts in place. Drain releases every held entry.
// Output stalls hold results. Reset clears state, fill count and output valid
// and loads the config defaults; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module packet_delay_emulator_queue_top #(
    parameter int CAPACITY    = pdeq_pkg::CAPACITY_DEF,
    parameter int FLUSH_COUNT = pdeq_pkg::FLUSH_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pdeq_pkg::CMD_W-1:0]      s_command,
    input  logic [pdeq_pkg::TAG_W-1:0]      s_packet_tag,
    input  logic                            s_packet_outbound,
    input  logic [pdeq_pkg::TIME_W-1:0]     s_now_ms,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_released,
    output logic [pdeq_pkg::TAG_W-1:0]      m_released_tag,
    output logic                            m_released_outbound,
    output logic                            m_last,
    output logic                            m_still_holding,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pdeq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pdeq_pkg::CFG_DATA_W-1:0] cfg_data
);

    import pdeq_pkg::*;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int FLUSH_N = (FLUSH_COUNT < CAPACITY) ? FLUSH_COUNT : CAPACITY;
    localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] FLUSH_C = CNT_W'(FLUSH_N);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARRIVE,
        ST_STATUS,
        ST_P1_RD,
        ST_P1_EV,
        ST_P2_RD,
        ST_P2_EV
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   final_reg, final_next;
    logic [CNT_W-1:0]   rel_total_reg, rel_total_next;
    logic [CNT_W-1:0]   keep_reg, keep_next;
    logic [CNT_W-1:0]   emit_reg, emit_next;
    logic [ADDR_W-1:0]  src_reg, src_next;
    logic [ADDR_W-1:0]  dst_reg, dst_next;
    logic               flush_reg, flush_next;
    logic               drain_reg, drain_next;

    logic [TAG_W-1:0]   tag_reg;
    logic               dir_reg;
    logic [TIME_W-1:0]  now_reg;

    logic               delay_en_reg, sel_in_reg, sel_out_reg;
    logic [DELAY_W-1:0] in_delay_reg, out_delay_reg;

    logic               m_valid_reg, m_valid_next;
    logic               m_released_reg, m_released_next;
    logic [TAG_W-1:0]   m_tag_reg, m_tag_next;
    logic               m_dir_reg, m_dir_next;
    logic               m_last_reg, m_last_next;
    logic               m_still_reg, m_still_next;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    entry_t             ram_wdata, ram_rdata;

    logic               in_acc, out_free, src_end, rel, arr_sel;
    logic [TIME_W-1:0]  elapsed;
    logic [DELAY_W-1:0] lim;
    logic [CNT_W-1:0]   keep_inc;

    pdeq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign src_end   = (CNT_W'(src_reg) + CNT_W'(1)) == count_reg;

    assign arr_sel   = delay_en_reg && (dir_reg ? sel_out_reg : sel_in_reg);

    // release test on the entry just read
    assign lim     = ram_rdata.outbound ? out_delay_reg : in_delay_reg;
    assign elapsed = now_reg - ram_rdata.stamp;
    always_comb begin
        if (drain_reg) begin
            rel = 1'b1;
        end else if (flush_reg) begin
            rel = CNT_W'(src_reg) < FLUSH_C;
        end else begin
            rel = !(delay_en_reg && (ram_rdata.outbound ? sel_out_reg : sel_in_reg))
                  || (elapsed > {{(TIME_W-DELAY_W){1'b0}}, lim});
        end
    end
    assign keep_inc = keep_reg + CNT_W'(!rel);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        final_next      = final_reg;
        rel_total_next  = rel_total_reg;
        keep_next       = keep_reg;
        emit_next       = emit_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        flush_next      = flush_reg;
        drain_next      = drain_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_released_next = m_released_reg;
        m_tag_next      = m_tag_reg;
        m_dir_next      = m_dir_reg;
        m_last_next     = m_last_reg;
        m_still_next    = m_still_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = dst_reg;
        ram_raddr       = src_reg;
        ram_wdata       = ram_rdata;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    src_next   = '0;
                    dst_next   = '0;
                    keep_next  = '0;
                    emit_next  = '0;
                    flush_next = 1'b0;
                    drain_next = 1'b0;
                    unique case (s_command)
                        CMD_ARRIVE: state_next = ST_ARRIVE;
                        CMD_TICK: begin
                            state_next = (count_reg == '0) ? ST_STATUS : ST_P1_RD;
                        end
                        CMD_DRAIN: begin
                            drain_next     = 1'b1;
                            final_next     = '0;
                            rel_total_next = count_reg;
                            state_next     = (count_reg == '0) ? ST_STATUS : ST_P2_RD;
                        end
                        default: state_next = ST_STATUS;
                    endcase
                end
            end
            ST_ARRIVE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    if (arr_sel && (count_reg < CAP_C)) begin
                        ram_we           = 1'b1;
                        ram_waddr        = count_reg[ADDR_W-1:0];
                        ram_wdata.outbound = dir_reg;
                        ram_wdata.tag    = tag_reg;
                        ram_wdata.stamp  = now_reg;
                        count_next       = count_reg + CNT_W'(1);
                        m_released_next  = 1'b0;
                        m_tag_next       = '0;
                        m_dir_next       = 1'b0;
                        m_still_next     = 1'b1;
                    end else begin
                        m_released_next  = 1'b1;
                        m_tag_next       = tag_reg;
                        m_dir_next       = dir_reg;
                        m_still_next     = (count_reg != '0);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_released_next = 1'b0;
                    m_tag_next      = '0;
                    m_dir_next      = 1'b0;
                    m_last_next     = 1'b1;
                    m_still_next    = (count_reg != '0);
                    state_next      = ST_IDLE;
                end
            end
            ST_P1_RD: begin
                ram_re     = 1'b1;
                state_next = ST_P1_EV;
            end
            ST_P1_EV: begin
                keep_next = keep_inc;
                if (src_end) begin
                    src_next = '0;
                    if (keep_inc == CAP_C) begin
                        flush_next     = 1'b1;
                        final_next     = CAP_C - FLUSH_C;
                        rel_total_next = FLUSH_C;
                        state_next     = ST_P2_RD;
                    end else begin
                        final_next     = keep_inc;
                        rel_total_next = count_reg - keep_inc;
                        state_next     = (keep_inc == count_reg) ? ST_STATUS : ST_P2_RD;
                    end
                end else begin
                    src_next   = src_reg + ADDR_W'(1);
                    state_next = ST_P1_RD;
                end
            end
            ST_P2_RD: begin
                ram_re     = 1'b1;
                state_next = ST_P2_EV;
            end
            ST_P2_EV: begin
                if (!rel || out_free) begin
                    if (rel) begin
                        m_valid_next    = 1'b1;
                        m_released_next = 1'b1;
                        m_tag_next      = ram_rdata.tag;
                        m_dir_next      = ram_rdata.outbound;
                        m_last_next     = (emit_reg + CNT_W'(1)) == rel_total_reg;
                        m_still_next    = (final_reg != '0);
                        emit_next       = emit_reg + CNT_W'(1);
                    end else begin
                        ram_we   = 1'b1;
                        dst_next = dst_reg + ADDR_W'(1);
                    end
                    if (src_end) begin
                        count_next = final_reg;
                        state_next = ST_IDLE;
                    end else begin
                        src_next   = src_reg + ADDR_W'(1);
                        state_next = ST_P2_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            tag_reg <= s_packet_tag;
            dir_reg <= s_packet_outbound;
            now_reg <= s_now_ms;
        end
        final_reg      <= final_next;
        rel_total_reg  <= rel_total_next;
        keep_reg       <= keep_next;
        emit_reg       <= emit_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        m_released_reg <= m_released_next;
        m_tag_reg      <= m_tag_next;
        m_dir_reg      <= m_dir_next;
        m_last_reg     <= m_last_next;
        m_still_reg    <= m_still_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            flush_reg     <= 1'b0;
            drain_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            delay_en_reg  <= DELAY_EN_RST;
            sel_in_reg    <= SEL_IN_RST;
            sel_out_reg   <= SEL_OUT_RST;
            in_delay_reg  <= IN_DELAY_RST;
            out_delay_reg <= OUT_DELAY_RST;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            flush_reg   <= flush_next;
            drain_reg   <= drain_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_DELAY_EN:  delay_en_reg  <= cfg_data[0];
                    REG_SEL_IN:    sel_in_reg    <= cfg_data[0];
                    REG_SEL_OUT:   sel_out_reg   <= cfg_data[0];
                    REG_IN_DELAY:  in_delay_reg  <= cfg_data[DELAY_W-1:0];
                    REG_OUT_DELAY: out_delay_reg <= cfg_data[DELAY_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_released          = m_released_reg;
    assign m_released_tag      = m_tag_reg;
    assign m_released_outbound = m_dir_reg;
    assign m_last              = m_last_reg;
    assign m_still_holding     = m_still_reg;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for packet_delay_emulator_queue_top. A behavioural
// model of the tag store predicts every result of each accepted request.
// The checker compares each result with the oldest prediction. Directed
// tests cover reset values, register masking, delay thresholds, wrap,
// direction select, a full store and output back-pressure. Randomised
// traffic phases with random idling on both sides follow.
// ----------------------------------------------------------------------------
module testbench;
    import pdeq_pkg::*;

    localparam int STORE_DEPTH = CAPACITY_DEF;
    localparam int FLUSH_DEPTH = FLUSH_COUNT_DEF;
    localparam int SETTLE      = 4 * STORE_DEPTH + 40;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic             released;
        logic [TAG_W-1:0] tag;
        logic             outbound;
        logic             last;
        logic             still_holding;
    } release_t;

    logic                  aclk              = 1'b0;
    logic                  aresetn           = 1'b0;
    logic                  s_valid           = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_command         = '0;
    logic [TAG_W-1:0]      s_packet_tag      = '0;
    logic                  s_packet_outbound = 1'b0;
    logic [TIME_W-1:0]     s_now_ms          = '0;
    logic                  m_valid;
    logic                  m_ready           = 1'b0;
    logic                  m_released;
    logic [TAG_W-1:0]      m_released_tag;
    logic                  m_released_outbound;
    logic                  m_last;
    logic                  m_still_holding;
    logic                  cfg_valid         = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index         = '0;
    logic [CFG_DATA_W-1:0] cfg_data          = '0;

    // model state
    logic               dly_en  = DELAY_EN_RST;
    logic               sel_in  = SEL_IN_RST;
    logic               sel_out = SEL_OUT_RST;
    logic [DELAY_W-1:0] in_dly  = IN_DELAY_RST;
    logic [DELAY_W-1:0] out_dly = OUT_DELAY_RST;
    entry_t             held_shadow[$];
    release_t           pending_releases[$];

    int                 fail_count  = 0;
    int                 idle_cycles = 0;
    bit                 tx_idle     = 1'b0;
    bit                 rx_idle     = 1'b0;
    int                 hold_seq    = 0;
    int                 hold_seen   = 0;
    int                 rx_hold     = 0;
    int                 rx_wait     = 0;
    logic [TIME_W-1:0]  sim_ms      = '0;

    packet_delay_emulator_queue_top dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_command           (s_command),
        .s_packet_tag        (s_packet_tag),
        .s_packet_outbound   (s_packet_outbound),
        .s_now_ms            (s_now_ms),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_released          (m_released),
        .m_released_tag      (m_released_tag),
        .m_released_outbound (m_released_outbound),
        .m_last              (m_last),
        .m_still_holding     (m_still_holding),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic bit dir_held(logic ob);
        return dly_en && (ob ? sel_out : sel_in);
    endfunction

    function automatic release_t released_item(logic [TAG_W-1:0] p_tag, logic ob);
        release_t r;
        r          = '0;
        r.released = 1'b1;
        r.tag      = p_tag;
        r.outbound = ob;
        return r;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_DELAY_EN:  dly_en  = data[0];
            REG_SEL_IN:    sel_in  = data[0];
            REG_SEL_OUT:   sel_out = data[0];
            REG_IN_DELAY:  in_dly  = data[DELAY_W-1:0];
            REG_OUT_DELAY: out_dly = data[DELAY_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void predict_release(logic [CMD_W-1:0] cmd, logic [TAG_W-1:0] p_tag,
                                            logic ob, logic [TIME_W-1:0] now);
        release_t          batch[$];
        entry_t            kept[$];
        entry_t            e;
        logic [TIME_W-1:0] elapsed;
        logic [DELAY_W-1:0] lim;
        int                n;
        case (cmd)
            CMD_ARRIVE: begin
                if (!dir_held(ob) || held_shadow.size() >= STORE_DEPTH)
                    batch.push_back(released_item(p_tag, ob));
                else
                    held_shadow.push_back('{outbound: ob, tag: p_tag, stamp: now});
            end
            CMD_TICK: begin
                foreach (held_shadow[i]) begin
                    e       = held_shadow[i];
                    lim     = e.outbound ? out_dly : in_dly;
                    elapsed = now - e.stamp;
                    if (!dir_held(e.outbound) || elapsed > TIME_W'(lim))
                        batch.push_back(released_item(e.tag, e.outbound));
                    else
                        kept.push_back(e);
                end
                held_shadow = kept;
                if (held_shadow.size() >= STORE_DEPTH) begin
                    n = (held_shadow.size() < FLUSH_DEPTH) ? held_shadow.size() : FLUSH_DEPTH;
                    repeat (n) begin
                        e = held_shadow.pop_front();
                        batch.push_back(released_item(e.tag, e.outbound));
                    end
                end
            end
            CMD_DRAIN: begin
                while (held_shadow.size() != 0) begin
                    e = held_shadow.pop_front();
                    batch.push_back(released_item(e.tag, e.outbound));
                end
            end
            default: ;
        endcase
        if (batch.size() == 0)
            batch.push_back('0);
        foreach (batch[i]) begin
            batch[i].still_holding = (held_shadow.size() != 0);
            batch[i].last          = (i == batch.size() - 1);
            pending_releases.push_back(batch[i]);
        end
    endfunction

    function automatic void report_mismatch(string what, release_t want, release_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display({"%0t %s: want rel=%0b tag=%h out=%0b last=%0b hold=%0b,",
                      " got rel=%0b tag=%h out=%0b last=%0b hold=%0b"},
                     $time, what, want.released, want.tag, want.outbound, want.last,
                     want.still_holding, got.released, got.tag, got.outbound, got.last,
                     got.still_holding);
    endfunction

    function automatic void check_release();
        release_t got;
        release_t want;
        got = '{released: m_released, tag: m_released_tag, outbound: m_released_outbound,
                last: m_last, still_holding: m_still_holding};
        if (pending_releases.size() == 0) begin
            report_mismatch("unexpected result", '0, got);
        end else begin
            want = pending_releases.pop_front();
            if (got !== want)
                report_mismatch("result mismatch", want, got);
        end
    endfunction

    // result side: check, random stalls, long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait  = 0;
            rx_hold  = 0;
        end else begin
            if (m_valid && m_ready)
                check_release();
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                rx_hold   = HOLD_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                rx_wait = rx_idle ? $urandom_range(0, 19) : 0;
                m_ready <= (rx_wait == 0);
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= (rx_wait == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t timeout: no handshake for %0d cycles", $time, idle_cycles);
                $display("[packet_delay_emulator_queue_top] ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] p_tag,
                             input logic ob, input logic [TIME_W-1:0] now);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_command         <= cmd;
        s_packet_tag      <= p_tag;
        s_packet_outbound <= ob;
        s_now_ms          <= now;
        do @(posedge aclk); while (!s_ready);
        predict_release(cmd, p_tag, ob, now);
    endtask

    task automatic quiesce();
        s_valid <= 1'b0;
        while (pending_releases.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, data);
    endtask

    task automatic configure(input bit en, input bit si, input bit so,
                             input logic [DELAY_W-1:0] din, input logic [DELAY_W-1:0] dout);
        quiesce();
        write_reg(REG_DELAY_EN, CFG_DATA_W'(en));
        write_reg(REG_SEL_IN, CFG_DATA_W'(si));
        write_reg(REG_SEL_OUT, CFG_DATA_W'(so));
        write_reg(REG_IN_DELAY, din);
        write_reg(REG_OUT_DELAY, dout);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [DELAY_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return DELAY_W'($urandom_range(0, 80));
    endfunction

    // delay off after reset: everything passes, idle commands give status only
    task automatic test_reset_state();
        tx_idle  = 1'b1;
        rx_idle <= 1'b1;
        send_item(CMD_ARRIVE, 16'h0000, 1'b0, 32'h0000_0000);
        send_item(CMD_ARRIVE, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        send_item(CMD_TICK, 16'h1234, 1'b0, 32'h0000_0010);
        send_item(CMD_DRAIN, 16'h4321, 1'b1, 32'h0000_0020);
        send_item(CMD_UNUSED, 16'hA5A5, 1'b1, 32'h5A5A_5A5A);
    endtask

    task automatic test_register_masking();
        quiesce();
        for (int idx = int'(REG_OUT_DELAY) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), 16'hFFFF);
        write_reg(REG_DELAY_EN, 16'hFFFF);
        write_reg(REG_SEL_IN, 16'hFFFE);
        write_reg(REG_SEL_OUT, 16'hFFFD);
        write_reg(REG_IN_DELAY, 16'hFFFF);
        write_reg(REG_OUT_DELAY, 16'h0000);
        cfg_valid <= 1'b0;
        send_item(CMD_ARRIVE, 16'h00FF, 1'b0, 32'h0000_0000);
        send_item(CMD_ARRIVE, 16'hFF00, 1'b1, 32'h0000_0000);
        send_item(CMD_TICK, 16'h0000, 1'b0, 32'h0000_0001);
        send_item(CMD_DRAIN, 16'h0000, 1'b0, 32'h0000_0002);
    endtask

    // elapsed must exceed the delay; elapsed time wraps
    task automatic test_delay_threshold();
        logic [TIME_W-1:0] t0;
        t0 = 32'hFFFF_FFF8;
        configure(1'b1, 1'b1, 1'b1, 16'd10, 16'hFFFF);
        tx_idle = 1'b0;
        send_item(CMD_ARRIVE, 16'h0000, 1'b0, t0);
        send_item(CMD_ARRIVE, 16'hFFFF, 1'b1, t0);
        send_item(CMD_TICK, 16'h0000, 1'b0, t0 + 32'd10);
        send_item(CMD_TICK, 16'h0000, 1'b0, t0 + 32'd11);
        send_item(CMD_TICK, 16'h0000, 1'b0, t0 + 32'd65535);
        send_item(CMD_TICK, 16'h0000, 1'b0, t0 + 32'd65536);
        configure(1'b1, 1'b1, 1'b1, 16'd0, 16'd0);
        send_item(CMD_ARRIVE, 16'h0F0F, 1'b0, 32'h8000_0000);
        send_item(CMD_ARRIVE, 16'hF0F0, 1'b1, 32'h8000_0000);
        send_item(CMD_TICK, 16'h0000, 1'b0, 32'h8000_0000);
        send_item(CMD_TICK, 16'h0000, 1'b0, 32'h8000_0001);
    endtask

    // deselecting a direction or disabling delay releases held entries
    task automatic test_direction_select();
        configure(1'b1, 1'b1, 1'b1, 16'd1000, 16'd1000);
        tx_idle = 1'b1;
        send_item(CMD_ARRIVE, 16'h1111, 1'b0, 32'd100);
        send_item(CMD_ARRIVE, 16'h2222, 1'b1, 32'd100);
        configure(1'b1, 1'b1, 1'b0, 16'd1000, 16'd1000);
        send_item(CMD_ARRIVE, 16'h3333, 1'b1, 32'd101);
        send_item(CMD_TICK, 16'h0000, 1'b0, 32'd101);
        configure(1'b1, 1'b0, 1'b1, 16'd1000, 16'd1000);
        send_item(CMD_TICK, 16'h0000, 1'b0, 32'd102);
        configure(1'b1, 1'b1, 1'b1, 16'd1000, 16'd1000);
        send_item(CMD_ARRIVE, 16'h4444, 1'b0, 32'd103);
        configure(1'b0, 1'b1, 1'b1, 16'd1000, 16'd1000);
        send_item(CMD_ARRIVE, 16'h5555, 1'b0, 32'd104);
        send_item(CMD_TICK, 16'h0000, 1'b0, 32'd104);
    endtask

    // fill the store, overflow passes through, tick flushes the oldest
    task automatic test_store_full();
        logic [TIME_W-1:0] base;
        configure(1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
        tx_idle  = 1'b0;
        rx_idle <= 1'b1;
        base     = $urandom;
        for (int i = 0; i < STORE_DEPTH; i++)
            send_item(CMD_ARRIVE, TAG_W'($urandom), 1'($urandom_range(0, 1)), base + i);
        send_item(CMD_ARRIVE, TAG_W'($urandom), 1'($urandom_range(0, 1)), base + 32'd40);
        send_item(CMD_TICK, 16'h0000, 1'b0, base + 32'd40);
        send_item(CMD_ARRIVE, TAG_W'($urandom), 1'($urandom_range(0, 1)), base + 32'd41);
        send_item(CMD_DRAIN, 16'h0000, 1'b0, base + 32'd42);
    endtask

    // receiver holds off while requests keep coming, so the block backs up
    task automatic test_output_backpressure();
        configure(1'b0, 1'b1, 1'b1, 16'd50, 16'd50);
        tx_idle   = 1'b0;
        rx_idle  <= 1'b0;
        hold_seq <= hold_seq + 1;
        for (int i = 0; i < 10; i++)
            send_item(CMD_ARRIVE, TAG_W'($urandom), 1'($urandom_range(0, 1)), $urandom);
        send_item(CMD_TICK, 16'h0000, 1'b0, $urandom);
        send_item(CMD_DRAIN, 16'h0000, 1'b0, $urandom);
    endtask

    task automatic test_random_traffic();
        int r;
        for (int phase = 0; phase < 4; phase++) begin
            configure(($urandom_range(0, 4) != 0), ($urandom_range(0, 3) != 0),
                      ($urandom_range(0, 3) != 0), pick_delay(), pick_delay());
            tx_idle  = 1'($urandom_range(0, 1));
            rx_idle <= 1'($urandom_range(0, 1));
            sim_ms   = $urandom;
            for (int i = 0; i < 8; i++) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    sim_ms += $urandom_range(0, 30);
                    send_item(CMD_ARRIVE, TAG_W'($urandom), 1'($urandom_range(0, 1)), sim_ms);
                end else if (r < 85) begin
                    sim_ms += $urandom_range(0, 60);
                    send_item(CMD_TICK, TAG_W'($urandom), 1'($urandom_range(0, 1)), sim_ms);
                end else if (r < 92) begin
                    send_item(CMD_DRAIN, TAG_W'($urandom), 1'($urandom_range(0, 1)), sim_ms);
                end else if (r < 95) begin
                    send_item(CMD_UNUSED, TAG_W'($urandom), 1'($urandom_range(0, 1)), $urandom);
                end else begin
                    send_item(($urandom_range(0, 1) != 0) ? CMD_TICK : CMD_ARRIVE,
                              TAG_W'($urandom), 1'($urandom_range(0, 1)), $urandom);
                end
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_register_masking();
        test_delay_threshold();
        test_direction_select();
        test_store_full();
        test_output_backpressure();
        test_random_traffic();
        quiesce();
        if (fail_count == 0 && pending_releases.size() == 0) begin
            $display("[packet_delay_emulator_queue_top] OK");
        end else begin
            if (pending_releases.size() != 0)
                $display("%0d expected results never arrived", pending_releases.size());
            $display("[packet_delay_emulator_queue_top] ERROR");
        end
        $finish;
    end

endmodule
